// File: rtl/xse_pkg.sv
// Shared types, codes and helper functions of the x86 subset execute unit.
package xse_pkg;

    localparam int MEM_ADDR_BITS  = 16;
    localparam int ROW_BITS       = MEM_ADDR_BITS - 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] CMD_MOV = 3'd0;
    localparam logic [2:0] CMD_ADD = 3'd1;
    localparam logic [2:0] CMD_SUB = 3'd2;
    localparam logic [2:0] CMD_CMP = 3'd3;
    localparam logic [2:0] CMD_JNE = 3'd4;

    localparam logic [2:0] KIND_REG = 3'd0;
    localparam logic [2:0] KIND_IMM = 3'd1;
    localparam logic [2:0] KIND_DIR = 3'd2;
    localparam logic [2:0] KIND_BAS = 3'd3;

    localparam logic [2:0] REG_BX = 3'd3;
    localparam logic [2:0] REG_BP = 3'd5;
    localparam logic [2:0] REG_SI = 3'd6;
    localparam logic [2:0] REG_DI = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_KIND = 2'd1;
    localparam logic [1:0] ST_LAST_BYTE = 2'd2;
    localparam logic [1:0] ST_BAD_CMD  = 2'd3;

    localparam logic [MEM_ADDR_BITS-1:0] ADDR_LAST = '1;

    typedef logic [7:0][15:0] t_regs;

    typedef struct packed {
        logic [2:0]         command;
        logic [2:0]         dest_kind;
        logic [2:0]         dest_code;
        logic               dest_wide;
        logic [15:0]        dest_displacement;
        logic [2:0]         source_kind;
        logic [2:0]         source_code;
        logic               source_wide;
        logic [15:0]        source_displacement;
        logic [15:0]        immediate_value;
        logic signed [15:0] jump_offset;
    } t_instr;

    typedef struct packed {
        t_instr ins;
        logic   bad_cmd;
        logic   is_jne;
    } t_item;

    typedef struct packed {
        logic [ROW_BITS-1:0] rd_row_e;
        logic [ROW_BITS-1:0] rd_row_o;
        logic [ROW_BITS-1:0] wr_row_e;
        logic [ROW_BITS-1:0] wr_row_o;
        logic                we_e;
        logic                we_o;
        logic [7:0]          wd_e;
        logic [7:0]          wd_o;
    } t_mem_req;

    typedef struct packed {
        logic [7:0] rd_e;
        logic [7:0] rd_o;
    } t_mem_rsp;

    typedef struct packed {
        logic [1:0]  status;
        logic        zero_flag;
        logic        sign_flag;
        logic [15:0] program_counter;
        logic [15:0] result_value;
    } t_result;

    function automatic logic [ROW_BITS-1:0] row_even(input logic [MEM_ADDR_BITS-1:0] a);
        return ROW_BITS'(a[MEM_ADDR_BITS-1:1]) + ROW_BITS'(a[0]);
    endfunction

    function automatic logic [ROW_BITS-1:0] row_odd(input logic [MEM_ADDR_BITS-1:0] a);
        return ROW_BITS'(a[MEM_ADDR_BITS-1:1]);
    endfunction

    function automatic logic [15:0] base_of(input t_regs r, input logic [2:0] mode);
        logic [15:0] b;
        case (mode)
            3'd0: b = r[REG_BX] + r[REG_SI];
            3'd1: b = r[REG_BX] + r[REG_DI];
            3'd2: b = r[REG_BP] + r[REG_SI];
            3'd3: b = r[REG_BP] + r[REG_DI];
            3'd4: b = r[REG_SI];
            3'd5: b = r[REG_DI];
            3'd6: b = r[REG_BP];
            default: b = r[REG_BX];
        endcase
        return b;
    endfunction

    function automatic logic [MEM_ADDR_BITS-1:0] op_addr(input logic [2:0] kind,
                                                         input logic [15:0] disp,
                                                         input logic [15:0] base);
        logic [15:0] s;
        s = (kind == KIND_DIR) ? disp : base + disp;
        return s[MEM_ADDR_BITS-1:0];
    endfunction

    function automatic logic [15:0] reg_value(input t_regs r, input logic [2:0] code,
                                              input logic wide);
        logic [15:0] v;
        if (wide) begin
            v = r[code];
        end else if (code[2]) begin
            v = {8'h00, r[{1'b0, code[1:0]}][15:8]};
        end else begin
            v = {8'h00, r[{1'b0, code[1:0]}][7:0]};
        end
        return v;
    endfunction

    function automatic logic [15:0] mem_value(input t_mem_rsp m, input logic a0,
                                              input logic wide);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = a0 ? m.rd_o : m.rd_e;
        hi = a0 ? m.rd_e : m.rd_o;
        return wide ? {hi, lo} : {8'h00, lo};
    endfunction

    function automatic logic [1:0] read_status(input logic [2:0] kind, input logic wide,
                                               input logic [MEM_ADDR_BITS-1:0] a);
        logic [1:0] s;
        if (kind == KIND_REG || kind == KIND_IMM) begin
            s = ST_OK;
        end else if (kind == KIND_DIR || kind == KIND_BAS) begin
            s = (wide && a == ADDR_LAST) ? ST_LAST_BYTE : ST_OK;
        end else begin
            s = ST_BAD_KIND;
        end
        return s;
    endfunction

    function automatic logic [1:0] write_status(input logic [2:0] kind, input logic wide,
                                                input logic [MEM_ADDR_BITS-1:0] a);
        logic [1:0] s;
        if (kind == KIND_REG) begin
            s = ST_OK;
        end else if (kind == KIND_DIR || kind == KIND_BAS) begin
            s = (wide && a == ADDR_LAST) ? ST_LAST_BYTE : ST_OK;
        end else begin
            s = ST_BAD_KIND;
        end
        return s;
    endfunction

endpackage

// File: rtl/x86_subset_execute_unit.sv
// Top level of the x86 subset execute unit: front queue, execution back end, data memory.
// Each request passes from the front queue through the back end's fetch, execute and write
// back sequence around the registered-read data memory, and write back waits for a free
// result register. The back end takes one request at a time; the front queue holds two.
// Reset: synchronous active-low; registers, flags and PC clear at once, then a clearing pass
// over every row of both banks zeroes the memory, during which no request is accepted.
module x86_subset_execute_unit import xse_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command, dest_kind, dest_code, dest_wide, dest_displacement, source_kind,
    // source_code, source_wide, source_displacement, immediate_value, jump_offset
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, zero_flag, sign_flag, program_counter, result_value
    output logic [39:0] m_axis_tdata
);

    t_instr   instr;
    t_item    q_item;
    logic     q_valid;
    logic     q_pop;
    logic     clearing;
    t_mem_req mem_req;
    t_mem_rsp mem_rsp;
    t_result  res;

    always_comb begin
        instr.command             = s_axis_tdata[2:0];
        instr.dest_kind           = s_axis_tdata[5:3];
        instr.dest_code           = s_axis_tdata[8:6];
        instr.dest_wide           = s_axis_tdata[9];
        instr.dest_displacement   = s_axis_tdata[25:10];
        instr.source_kind         = s_axis_tdata[28:26];
        instr.source_code         = s_axis_tdata[31:29];
        instr.source_wide         = s_axis_tdata[32];
        instr.source_displacement = s_axis_tdata[48:33];
        instr.immediate_value     = s_axis_tdata[64:49];
        instr.jump_offset         = s_axis_tdata[80:65];
    end

    xse_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (clearing),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_instr (instr),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    xse_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    xse_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_mem      (mem_req),
        .i_mem      (mem_rsp),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (res)
    );

    assign m_axis_tdata = {4'h0, res.result_value, res.program_counter,
                           res.sign_flag, res.zero_flag, res.status};

endmodule

// File: rtl/xse_front.sv
// Front end: accepts instructions, classifies the command and queues them.
module xse_front import xse_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_hold,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_instr i_instr,
    output logic   o_valid,
    input  logic   i_pop,
    output t_item  o_item
);

    t_item                     r_q [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wp;
    logic [QUEUE_PTR_BITS-1:0] r_rp;
    logic [QUEUE_CNT_BITS-1:0] r_cnt;
    logic                      push;
    logic                      pop;
    t_item                     cls;

    always_comb begin
        cls.ins     = i_instr;
        cls.bad_cmd = (i_instr.command > CMD_JNE);
        cls.is_jne  = (i_instr.command == CMD_JNE);
    end

    assign o_ready = (r_cnt != QUEUE_CNT_BITS'(QUEUE_DEPTH)) && !i_hold;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cls;
                r_wp      <= (r_wp == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                             : r_wp + QUEUE_PTR_BITS'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : r_rp + QUEUE_PTR_BITS'(1);
            end
            r_cnt <= r_cnt + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
        end
    end

endmodule

// File: rtl/xse_mem.sv
// Byte data memory split into even and odd banks with registered reads.
module xse_mem import xse_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    logic [7:0] r_bank_e [2**ROW_BITS];
    logic [7:0] r_bank_o [2**ROW_BITS];

    always_ff @(posedge i_clk) begin
        o_rsp.rd_e <= r_bank_e[i_req.rd_row_e];
        o_rsp.rd_o <= r_bank_o[i_req.rd_row_o];
        if (i_req.we_e) begin
            r_bank_e[i_req.wr_row_e] <= i_req.wd_e;
        end
        if (i_req.we_o) begin
            r_bank_o[i_req.wr_row_o] <= i_req.wd_o;
        end
    end

endmodule

// File: rtl/xse_exec.sv
// Back end: memory clear after reset, operand fetch, execution, write back, flags, PC and result register.
module xse_exec import xse_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_item    i_item,
    output logic     o_pop,
    output logic     o_clearing,
    output t_mem_req o_mem,
    input  t_mem_rsp i_mem,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_result
);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_RDS, S_RDD, S_EXE, S_WB} t_state;

    t_state                  r_state, n_state;
    logic [ROW_BITS-1:0]     r_clr_row, n_clr_row;
    t_item                   r_it, n_it;
    logic [MEM_ADDR_BITS-1:0] r_sa, n_sa, r_da, n_da;
    logic [15:0]             r_sv, n_sv;
    logic [15:0]             r_res, n_res;
    logic [1:0]              r_st, n_st;
    t_regs                   r_regs, n_regs;
    logic                    r_zf, n_zf, r_sf, n_sf;
    logic [15:0]             r_pc, n_pc;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_out, n_out;

    logic [15:0] dv;
    logic [1:0]  st_src, st_dst, st_wr;
    logic        out_free;
    logic        wr_mem;
    logic [2:0]  cmd;

    assign cmd      = r_it.ins.command;
    assign out_free = !r_out_valid || i_ready;
    assign wr_mem   = (r_state == S_WB) && out_free && (r_st == ST_OK) && !r_it.bad_cmd
                      && (cmd == CMD_MOV || cmd == CMD_ADD || cmd == CMD_SUB)
                      && r_it.ins.dest_kind != KIND_REG;

    always_comb begin
        n_state     = r_state;
        n_clr_row   = r_clr_row;
        n_it        = r_it;
        n_sa        = r_sa;
        n_da        = r_da;
        n_sv        = r_sv;
        n_res       = r_res;
        n_st        = r_st;
        n_regs      = r_regs;
        n_zf        = r_zf;
        n_sf        = r_sf;
        n_pc        = r_pc;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        dv          = mem_value(i_mem, r_da[0], r_it.ins.dest_wide);
        st_src      = read_status(r_it.ins.source_kind, r_it.ins.source_wide, r_sa);
        st_dst      = read_status(r_it.ins.dest_kind, r_it.ins.dest_wide, r_da);
        st_wr       = write_status(r_it.ins.dest_kind, r_it.ins.dest_wide, r_da);

        o_mem.rd_row_e = (r_state == S_RDS) ? row_even(r_sa) : row_even(r_da);
        o_mem.rd_row_o = (r_state == S_RDS) ? row_odd(r_sa) : row_odd(r_da);
        o_mem.wr_row_e = row_even(r_da);
        o_mem.wr_row_o = row_odd(r_da);
        o_mem.we_e     = wr_mem && (r_it.ins.dest_wide || !r_da[0]);
        o_mem.we_o     = wr_mem && (r_it.ins.dest_wide || r_da[0]);
        o_mem.wd_e     = r_da[0] ? r_res[15:8] : r_res[7:0];
        o_mem.wd_o     = r_da[0] ? r_res[7:0] : r_res[15:8];

        case (r_state)
            S_CLR: begin
                o_mem.wr_row_e = r_clr_row;
                o_mem.wr_row_o = r_clr_row;
                o_mem.we_e     = 1'b1;
                o_mem.we_o     = 1'b1;
                o_mem.wd_e     = 8'h00;
                o_mem.wd_o     = 8'h00;
                n_clr_row      = r_clr_row + ROW_BITS'(1);
                if (r_clr_row == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_it    = i_item;
                    n_sa    = op_addr(i_item.ins.source_kind, i_item.ins.source_displacement,
                                      base_of(r_regs, i_item.ins.source_code));
                    n_da    = op_addr(i_item.ins.dest_kind, i_item.ins.dest_displacement,
                                      base_of(r_regs, i_item.ins.dest_code));
                    n_state = S_RDS;
                end
            end
            S_RDS: begin
                n_state = S_RDD;
            end
            S_RDD: begin
                if (r_it.ins.source_kind == KIND_REG) begin
                    n_sv = reg_value(r_regs, r_it.ins.source_code, r_it.ins.source_wide);
                end else if (r_it.ins.source_kind == KIND_IMM) begin
                    n_sv = r_it.ins.immediate_value;
                end else begin
                    n_sv = mem_value(i_mem, r_sa[0], r_it.ins.source_wide);
                end
                n_state = S_EXE;
            end
            S_EXE: begin
                if (r_it.ins.dest_kind == KIND_REG) begin
                    dv = reg_value(r_regs, r_it.ins.dest_code, r_it.ins.dest_wide);
                end else if (r_it.ins.dest_kind == KIND_IMM) begin
                    dv = r_it.ins.immediate_value;
                end
                if (r_it.bad_cmd) begin
                    n_st = ST_BAD_CMD;
                end else if (r_it.is_jne) begin
                    n_st = ST_OK;
                end else if (st_src != ST_OK) begin
                    n_st = st_src;
                end else if (cmd != CMD_MOV && st_dst != ST_OK) begin
                    n_st = st_dst;
                end else if (cmd != CMD_CMP && st_wr != ST_OK) begin
                    n_st = st_wr;
                end else begin
                    n_st = ST_OK;
                end
                case (cmd)
                    CMD_MOV: n_res = r_sv;
                    CMD_ADD: n_res = dv + r_sv;
                    CMD_SUB: n_res = dv - r_sv;
                    CMD_CMP: n_res = dv - r_sv;
                    default: n_res = 16'h0000;
                endcase
                n_state = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    if (r_it.is_jne) begin
                        if (!r_zf) begin
                            n_pc = r_pc + r_it.ins.jump_offset;
                        end
                    end else if (r_st == ST_OK && !r_it.bad_cmd) begin
                        if ((cmd == CMD_MOV || cmd == CMD_ADD || cmd == CMD_SUB)
                            && r_it.ins.dest_kind == KIND_REG) begin
                            if (r_it.ins.dest_wide) begin
                                n_regs[r_it.ins.dest_code] = r_res;
                            end else if (r_it.ins.dest_code[2]) begin
                                n_regs[{1'b0, r_it.ins.dest_code[1:0]}][15:8] = r_res[7:0];
                            end else begin
                                n_regs[{1'b0, r_it.ins.dest_code[1:0]}][7:0] = r_res[7:0];
                            end
                        end
                        if (cmd != CMD_MOV) begin
                            n_zf = (r_res == 16'h0000);
                            n_sf = r_res[15];
                        end
                    end
                    n_out_valid           = 1'b1;
                    n_out.status          = r_st;
                    n_out.zero_flag       = n_zf;
                    n_out.sign_flag       = n_sf;
                    n_out.program_counter = n_pc;
                    n_out.result_value    = (r_st == ST_OK) ? r_res : 16'h0000;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_row   <= '0;
            r_regs      <= '0;
            r_zf        <= 1'b0;
            r_sf        <= 1'b0;
            r_pc        <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_regs      <= n_regs;
            r_zf        <= n_zf;
            r_sf        <= n_sf;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
        r_it  <= n_it;
        r_sa  <= n_sa;
        r_da  <= n_da;
        r_sv  <= n_sv;
        r_res <= n_res;
        r_st  <= n_st;
        r_out <= n_out;
    end

    assign o_clearing = (r_state == S_CLR);
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !r_out_valid) else $error("result during memory clear");

    a_fault_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.result_value == 16'h0000))
        else $error("faulted request reports a nonzero result");

    a_mem_write_in_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we_e || o_mem.we_o) |-> (r_state == S_CLR || r_state == S_WB))
        else $error("memory written outside write back");

    a_wb_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && out_free) |=> r_out_valid)
        else $error("write back did not load the result register");

endmodule
